// ----- rtl/eigen_calving_rate_cell_assert.svh -----
// ----------------------------------------------------------------------------
// Eigen calving rate cell assertion macros
// Concurrent property wrappers used by the calving cell to check itself.
// ----------------------------------------------------------------------------
`ifndef EIGEN_CALVING_RATE_CELL_ASSERT_SVH
`define EIGEN_CALVING_RATE_CELL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ecr_pkg.sv -----
// ----------------------------------------------------------------------------
// Eigen calving rate package
// Widths, register indexes, payload structs and constants of the calving cell.
// ----------------------------------------------------------------------------
package ecr_pkg;

    localparam int RATE_WIDTH = 32;
    localparam int NUM_NB     = 4;
    localparam int KGAIN_W    = 32;
    localparam int SHIFT_W    = 6;
    localparam int CALV_W     = 63;
    localparam int CNT_W      = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_K_GAIN       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_SHIFT = 1'b1;

    // Datapath widths derived from the strain-rate width.
    localparam int HALF_W = RATE_WIDTH + 1;
    localparam int SUM_W  = RATE_WIDTH + 2;
    localparam int MAG_W  = RATE_WIDTH + 1;
    localparam int E_W    = RATE_WIDTH - 1;
    localparam int P_W    = 2 * E_W;
    localparam int PP_W   = E_W + KGAIN_W;
    localparam int F_W    = P_W + KGAIN_W;
    localparam int EXT_W  = (F_W > CALV_W) ? F_W : CALV_W + 1;

    // Divide by three as a multiply by floor(2^k / 3) with k even, so that
    // the estimate is at most one below the true quotient.
    localparam int DIV3_SHIFT = RATE_WIDTH + (RATE_WIDTH % 2);
    localparam int DIV3_W     = MAG_W + DIV3_SHIFT;
    localparam logic [63:0] DIV3_MUL_FULL = ((64'd1 << DIV3_SHIFT) - 64'd1) / 64'd3;
    localparam logic [DIV3_SHIFT-1:0] DIV3_MUL = DIV3_MUL_FULL[DIV3_SHIFT-1:0];

    typedef struct packed {
        logic                         center_ice_free_ocean;
        logic                         center_next_to_floating;
        logic [NUM_NB-1:0]            neighbour_floating;
        logic [NUM_NB-1:0]            neighbour_margin;
        logic signed [RATE_WIDTH-1:0] west_first_rate;
        logic signed [RATE_WIDTH-1:0] west_second_rate;
        logic signed [RATE_WIDTH-1:0] east_first_rate;
        logic signed [RATE_WIDTH-1:0] east_second_rate;
        logic signed [RATE_WIDTH-1:0] south_first_rate;
        logic signed [RATE_WIDTH-1:0] south_second_rate;
        logic signed [RATE_WIDTH-1:0] north_first_rate;
        logic signed [RATE_WIDTH-1:0] north_second_rate;
    } ecr_in_t;

    typedef struct packed {
        logic [CALV_W-1:0] calving_rate;
        logic [CNT_W-1:0]  used_neighbours;
    } ecr_out_t;

    // Load enables of the four stages inside the averaging unit.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } ecr_avg_en_t;

endpackage

// ----- rtl/ecr_average.sv -----
// ----------------------------------------------------------------------------
// Eigen calving rate neighbour average
// Four-stage mean of one signed strain rate over the qualifying neighbours,
// truncated toward zero and valid only if strictly positive, as flagged.
// ----------------------------------------------------------------------------
module ecr_average import ecr_pkg::*; (
    input  logic                         aclk,
    input  ecr_avg_en_t                  en,
    input  logic [NUM_NB-1:0]            qual,
    input  logic signed [RATE_WIDTH-1:0] rate_w,
    input  logic signed [RATE_WIDTH-1:0] rate_e,
    input  logic signed [RATE_WIDTH-1:0] rate_s,
    input  logic signed [RATE_WIDTH-1:0] rate_n,
    output logic [E_W-1:0]               avg_q,
    output logic                         avg_pos,
    output logic [CNT_W-1:0]             avg_cnt
);

    logic signed [HALF_W-1:0] half_a_reg, half_b_reg, half_a_next, half_b_next;
    logic [CNT_W-1:0]         cnt1_reg, cnt2_reg, cnt3_reg, cnt4_reg, cnt1_next;
    logic signed [SUM_W-1:0]  sum2;
    logic                     pos2_reg, pos3_reg, pos4_reg, pos2_next, pos4_next;
    logic [MAG_W-1:0]         mag2_reg, mag3_reg, mag2_next;
    logic [DIV3_W-1:0]        prod3_reg, prod3_next;
    logic [MAG_W-1:0]         q0, rem, quot;
    logic [E_W-1:0]           avg4_reg, avg4_next;

    // Stage 1: masked pairwise sums and neighbour count.
    always_comb begin
        half_a_next = (qual[0] ? HALF_W'(rate_w) : '0) + (qual[1] ? HALF_W'(rate_e) : '0);
        half_b_next = (qual[2] ? HALF_W'(rate_s) : '0) + (qual[3] ? HALF_W'(rate_n) : '0);
        cnt1_next   = CNT_W'(qual[0]) + CNT_W'(qual[1]) + CNT_W'(qual[2]) + CNT_W'(qual[3]);
    end

    // Stage 2: full sum; a positive sum always fits in MAG_W bits.
    always_comb begin
        sum2      = SUM_W'(half_a_reg) + SUM_W'(half_b_reg);
        pos2_next = !sum2[SUM_W-1] && (sum2 != '0);
        mag2_next = sum2[MAG_W-1:0];
    end

    // Stage 3: reciprocal product for the divide by three.
    assign prod3_next = DIV3_W'(mag2_reg) * DIV3_W'(DIV3_MUL);

    // Stage 4: correct the estimate by one and pick the divisor.
    always_comb begin
        q0   = prod3_reg[DIV3_SHIFT +: MAG_W];
        rem  = mag3_reg - ((q0 << 1) + q0);
        quot = '0;
        case (cnt3_reg)
            3'd1:    quot = mag3_reg;
            3'd2:    quot = mag3_reg >> 1;
            3'd3:    quot = (rem >= MAG_W'(3)) ? q0 + MAG_W'(1) : q0;
            3'd4:    quot = mag3_reg >> 2;
            default: quot = '0;
        endcase
        avg4_next = quot[E_W-1:0];
        pos4_next = pos3_reg && (quot != '0);
    end

    always_ff @(posedge aclk) begin
        if (en.ld1) begin
            half_a_reg <= half_a_next;
            half_b_reg <= half_b_next;
            cnt1_reg   <= cnt1_next;
        end
        if (en.ld2) begin
            pos2_reg <= pos2_next;
            mag2_reg <= mag2_next;
            cnt2_reg <= cnt1_reg;
        end
        if (en.ld3) begin
            prod3_reg <= prod3_next;
            mag3_reg  <= mag2_reg;
            pos3_reg  <= pos2_reg;
            cnt3_reg  <= cnt2_reg;
        end
        if (en.ld4) begin
            avg4_reg <= avg4_next;
            pos4_reg <= pos4_next;
            cnt4_reg <= cnt3_reg;
        end
    end

    assign avg_q   = avg4_reg;
    assign avg_pos = pos4_reg;
    assign avg_cnt = cnt4_reg;

endmodule

// ----- rtl/eigen_calving_rate_cell.sv -----
// Throughput: one cell per cycle while m_ready does not stall the output; eight
// register stages, each of which loads when it is empty or its successor moves,
// so stalls back up without loss.
// The stages hold the neighbor sums, the divide-by-three correction, the
// strain product and the split gain multiply. Reset (aresetn low, synchronous)
// empties the pipeline and clears k_gain and result_shift to zero.
// ----------------------------------------------------------------------------
// Eigen calving rate cell
// Calving rate of a front cell from neighbor-averaged principal strain rates.
// ----------------------------------------------------------------------------
`include "eigen_calving_rate_cell_assert.svh"

module eigen_calving_rate_cell import ecr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ecr_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ecr_out_t              m_data
);

    localparam int NSTAGE = 8;

    logic [KGAIN_W-1:0] k_gain_reg;
    logic [SHIFT_W-1:0] shift_reg;

    logic [NSTAGE:1] v_reg, v_next, ld;
    logic [NUM_NB-1:0] qual;
    ecr_avg_en_t       avg_en;

    logic [E_W-1:0]   avg1_q, avg2_q;
    logic             avg1_pos, avg2_pos;
    logic [CNT_W-1:0] cnt4;
    logic [CNT_W-1:0] cnt4_b;

    logic [P_W-1:0]   prod5_reg, prod5_next;
    logic             pos5_reg, pos5_next;
    logic [P_W-1:0]   prod_eff;
    logic [PP_W-1:0]  pl6_reg, ph6_reg, pl6_next, ph6_next;
    logic [F_W-1:0]   full7_reg, full7_next, shifted;
    logic [EXT_W-1:0] ext;
    logic [CNT_W-1:0] cnt5_reg, cnt6_reg, cnt7_reg;
    ecr_out_t         out_reg, out_next;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_gain_reg <= '0;
            shift_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_K_GAIN:       k_gain_reg <= cfg_wdata[KGAIN_W-1:0];
                REG_RESULT_SHIFT: shift_reg  <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        ld[NSTAGE]     = !v_reg[NSTAGE] || m_ready;
        for (int i = NSTAGE - 1; i >= 1; i--) begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
        v_next[1] = ld[1] ? s_valid : v_reg[1];
        for (int i = 2; i <= NSTAGE; i++) begin
            v_next[i] = ld[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = ld[1];
    assign m_valid = v_reg[NSTAGE];
    assign m_data  = out_reg;

    // Only a front cell averages; otherwise no neighbor qualifies.
    assign qual = (s_data.center_ice_free_ocean && s_data.center_next_to_floating)
                ? (s_data.neighbour_floating & ~s_data.neighbour_margin) : '0;

    assign avg_en = '{ld1: ld[1], ld2: ld[2], ld3: ld[3], ld4: ld[4]};

    ecr_average u_avg_first (
        .aclk    (aclk),
        .en      (avg_en),
        .qual    (qual),
        .rate_w  (s_data.west_first_rate),
        .rate_e  (s_data.east_first_rate),
        .rate_s  (s_data.south_first_rate),
        .rate_n  (s_data.north_first_rate),
        .avg_q   (avg1_q),
        .avg_pos (avg1_pos),
        .avg_cnt (cnt4)
    );

    ecr_average u_avg_second (
        .aclk    (aclk),
        .en      (avg_en),
        .qual    (qual),
        .rate_w  (s_data.west_second_rate),
        .rate_e  (s_data.east_second_rate),
        .rate_s  (s_data.south_second_rate),
        .rate_n  (s_data.north_second_rate),
        .avg_q   (avg2_q),
        .avg_pos (avg2_pos),
        .avg_cnt (cnt4_b)
    );

    // Stage 5: product of the two averages.
    assign prod5_next = P_W'(avg1_q) * P_W'(avg2_q);
    assign pos5_next  = avg1_pos && avg2_pos;

    // Stage 6: gain times each half of the product, zeroed unless both averages are positive.
    assign prod_eff = pos5_reg ? prod5_reg : '0;
    assign pl6_next = PP_W'(prod_eff[E_W-1:0]) * PP_W'(k_gain_reg);
    assign ph6_next = PP_W'(prod_eff[P_W-1:E_W]) * PP_W'(k_gain_reg);

    // Stage 7: recombine the partial products.
    assign full7_next = (F_W'(ph6_reg) << E_W) + F_W'(pl6_reg);

    // Stage 8: shift and saturate into the output register.
    always_comb begin
        shifted  = full7_reg >> shift_reg;
        ext      = EXT_W'(shifted);
        out_next.calving_rate    = (|ext[EXT_W-1:CALV_W]) ? '1 : ext[CALV_W-1:0];
        out_next.used_neighbours = cnt7_reg;
    end

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            prod5_reg <= prod5_next;
            pos5_reg  <= pos5_next;
            cnt5_reg  <= cnt4;
        end
        if (ld[6]) begin
            pl6_reg  <= pl6_next;
            ph6_reg  <= ph6_next;
            cnt6_reg <= cnt5_reg;
        end
        if (ld[7]) begin
            full7_reg <= full7_next;
            cnt7_reg  <= cnt6_reg;
        end
        if (ld[8]) begin
            out_reg <= out_next;
        end
    end

    `ECR_ASSERT_SAME(a_no_nb_zero_rate, aclk, aresetn, m_valid && (m_data.used_neighbours == '0), m_data.calving_rate == '0, "calving rate without qualifying neighbours")
    `ECR_ASSERT_SAME(a_pos_needs_count, aclk, aresetn, v_reg[4] && avg1_pos && avg2_pos, (cnt4 != '0) && (cnt4 <= 3'd4), "positive averages with bad neighbour count")
    `ECR_ASSERT_SAME(a_count_match, aclk, aresetn, v_reg[4], cnt4 == cnt4_b, "neighbour counts of the averages differ")
    `ECR_ASSERT_NEXT(a_stage_holds, aclk, aresetn, v_reg[5] && !ld[5], v_reg[5], "stalled pipeline stage lost its item")

endmodule
